// ===== src/seag_pkg.sv =====
// seag_pkg: shared types and constants for the scatter-elements address generator
// used by the register block, the controller, the datapath and the top level
package seag_pkg;

   localparam int DimRegW  = 13;  // width of a dimension register
   localparam int AxisW    = 2;   // width of the axis slot register
   localparam int IndexW   = 13;  // signed scatter index
   localparam int ValueW   = 32;  // update value bits
   localparam int CsrIdxW  = 3;   // register index on the configuration port
   localparam int NumDims  = 4;

   // configuration register indexes
   typedef enum logic [CsrIdxW-1:0] {
      CSR_OUT_DIM_N = 3'd0,
      CSR_OUT_DIM_C = 3'd1,
      CSR_OUT_DIM_H = 3'd2,
      CSR_OUT_DIM_W = 3'd3,
      CSR_UPD_DIM_C = 3'd4,
      CSR_UPD_DIM_H = 3'd5,
      CSR_UPD_DIM_W = 3'd6,
      CSR_AXIS_SLOT = 3'd7
   } csr_idx_type;

   // address steps: slot 0 seeds the accumulator, slots 1..3 multiply in
   localparam logic [1:0] FirstStep = 2'd1;
   localparam logic [1:0] LastStep  = 2'd3;

   typedef struct packed {
      logic [NumDims-1:0][DimRegW-1:0] out_dim;  // index 0 = n .. 3 = w
      logic [DimRegW-1:0]              upd_c;
      logic [DimRegW-1:0]              upd_h;
      logic [DimRegW-1:0]              upd_w;
      logic [AxisW-1:0]                axis_slot;
   } cfg_type;

   typedef struct packed {
      logic       load;  // capture an input transfer
      logic       step;  // one multiply-accumulate step
      logic [1:0] sel;   // dimension used by the step
      logic       emit;  // move the finished address to the output register
   } cmd_type;

endpackage

// ===== src/seag_csr.sv =====
// seag_csr: configuration registers of the scatter-elements address generator
// depends on seag_pkg
module seag_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [seag_pkg::CsrIdxW-1:0]   csr_index,
   input  logic [seag_pkg::DimRegW-1:0]   csr_wdata,
   output seag_pkg::cfg_type              cfg
);

   seag_pkg::cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.out_dim   <= {seag_pkg::NumDims{seag_pkg::DimRegW'(1)}};
         cfg_ff.upd_c     <= seag_pkg::DimRegW'(1);
         cfg_ff.upd_h     <= seag_pkg::DimRegW'(1);
         cfg_ff.upd_w     <= seag_pkg::DimRegW'(1);
         cfg_ff.axis_slot <= seag_pkg::AxisW'(3);
      end else if (csr_we) begin
         unique case (seag_pkg::csr_idx_type'(csr_index))
            seag_pkg::CSR_OUT_DIM_N: cfg_ff.out_dim[0] <= csr_wdata;
            seag_pkg::CSR_OUT_DIM_C: cfg_ff.out_dim[1] <= csr_wdata;
            seag_pkg::CSR_OUT_DIM_H: cfg_ff.out_dim[2] <= csr_wdata;
            seag_pkg::CSR_OUT_DIM_W: cfg_ff.out_dim[3] <= csr_wdata;
            seag_pkg::CSR_UPD_DIM_C: cfg_ff.upd_c      <= csr_wdata;
            seag_pkg::CSR_UPD_DIM_H: cfg_ff.upd_h      <= csr_wdata;
            seag_pkg::CSR_UPD_DIM_W: cfg_ff.upd_w      <= csr_wdata;
            seag_pkg::CSR_AXIS_SLOT: cfg_ff.axis_slot  <= csr_wdata[seag_pkg::AxisW-1:0];
            default: ;
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== src/seag_ctrl.sv =====
// seag_ctrl: controller of the scatter-elements address generator
// sequences capture, three multiply steps and the output transfer; depends on seag_pkg
module seag_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   output seag_pkg::cmd_type cmd
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CALC,
      ST_HOLD
   } state_type;

   state_type  state_ff;
   logic [1:0] sel_ff;
   logic       rsp_valid_ff;

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   assign cmd.load = req_tvalid && (state_ff == ST_IDLE);
   assign cmd.step = (state_ff == ST_CALC);
   assign cmd.sel  = sel_ff;
   assign cmd.emit = (state_ff == ST_HOLD) && (!rsp_valid_ff || rsp_tready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sel_ff       <= seag_pkg::FirstStep;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (req_tvalid) begin
                  state_ff <= ST_CALC;
                  sel_ff   <= seag_pkg::FirstStep;
               end
            end
            ST_CALC: begin
               if (sel_ff == seag_pkg::LastStep) begin
                  state_ff <= ST_HOLD;
               end else begin
                  sel_ff <= sel_ff + 2'd1;
               end
            end
            ST_HOLD: begin
               if (!rsp_valid_ff || rsp_tready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
         // output register: filled by the controller, drained by the receiver
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule

// ===== src/seag_dp.sv =====
// seag_dp: datapath of the scatter-elements address generator
// coordinate counters, index wrap, shared multiply-accumulate and output register
// depends on seag_pkg
module seag_dp #(
   parameter int ADDR_BITS = 24,
   parameter int DIM_BITS  = 12
) (
   input  logic                                clock,
   input  logic                                reset,
   input  seag_pkg::cfg_type                   cfg,
   input  seag_pkg::cmd_type                   cmd,
   input  logic signed [seag_pkg::IndexW-1:0]  scatter_index,
   input  logic [seag_pkg::ValueW-1:0]         update_value,
   output logic [ADDR_BITS-1:0]                write_addr,
   output logic [seag_pkg::ValueW-1:0]         write_value,
   output logic                                addr_valid
);

   // coordinate width: a counter or a wrapped index
   localparam int CW = (DIM_BITS > seag_pkg::DimRegW) ? DIM_BITS : seag_pkg::DimRegW;
   // counter compare width
   localparam int NW = (DIM_BITS + 1 > seag_pkg::DimRegW) ? DIM_BITS + 1 : seag_pkg::DimRegW;
   // accumulate width: product plus one carry bit
   localparam int AW = ADDR_BITS + seag_pkg::DimRegW + 1;
   localparam int WW = seag_pkg::DimRegW + 2;  // wrapped index, signed

   // update coordinate counters
   logic [DIM_BITS-1:0] coord_n_ff, coord_c_ff, coord_h_ff, coord_w_ff;
   logic [DIM_BITS-1:0] coord_n_in, coord_c_in, coord_h_in, coord_w_in;
   logic [DIM_BITS:0]   w_next, h_next, c_next;
   logic                w_wrap, h_wrap, c_wrap;

   assign w_next = {1'b0, coord_w_ff} + (DIM_BITS+1)'(1);
   assign h_next = {1'b0, coord_h_ff} + (DIM_BITS+1)'(1);
   assign c_next = {1'b0, coord_c_ff} + (DIM_BITS+1)'(1);
   assign w_wrap = (NW'(w_next) >= NW'(cfg.upd_w)) || w_next[DIM_BITS];
   assign h_wrap = (NW'(h_next) >= NW'(cfg.upd_h)) || h_next[DIM_BITS];
   assign c_wrap = (NW'(c_next) >= NW'(cfg.upd_c)) || c_next[DIM_BITS];

   always_comb begin
      coord_w_in = w_wrap ? '0 : w_next[DIM_BITS-1:0];
      coord_h_in = coord_h_ff;
      coord_c_in = coord_c_ff;
      coord_n_in = coord_n_ff;
      if (w_wrap) begin
         coord_h_in = h_wrap ? '0 : h_next[DIM_BITS-1:0];
         if (h_wrap) begin
            coord_c_in = c_wrap ? '0 : c_next[DIM_BITS-1:0];
            if (c_wrap) begin
               coord_n_in = coord_n_ff + DIM_BITS'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coord_n_ff <= '0;
         coord_c_ff <= '0;
         coord_h_ff <= '0;
         coord_w_ff <= '0;
      end else if (cmd.load) begin
         coord_n_ff <= coord_n_in;
         coord_c_ff <= coord_c_in;
         coord_h_ff <= coord_h_in;
         coord_w_ff <= coord_w_in;
      end
   end

   // index wrap and range check against the scatter axis dimension
   logic [seag_pkg::DimRegW-1:0] axis_dim;
   logic signed [WW-1:0]         idx_ext, idx_wrapped;
   logic                         idx_ok;

   assign axis_dim    = cfg.out_dim[cfg.axis_slot];
   assign idx_ext     = WW'(scatter_index);
   assign idx_wrapped = idx_ext[WW-1] ? (idx_ext + $signed({2'b00, axis_dim})) : idx_ext;
   assign idx_ok      = !idx_wrapped[WW-1]
                        && (idx_wrapped[seag_pkg::DimRegW-1:0] < axis_dim);

   // operand coordinates with the scatter axis replaced
   logic [seag_pkg::NumDims-1:0][CW-1:0] op_coord_ff, op_coord_in;
   logic [seag_pkg::NumDims-1:0][CW-1:0] cur_coord;

   assign cur_coord = {CW'(coord_w_ff), CW'(coord_h_ff), CW'(coord_c_ff), CW'(coord_n_ff)};

   always_comb begin
      for (int k = 0; k < seag_pkg::NumDims; k++) begin
         if (cfg.axis_slot == seag_pkg::AxisW'(k)) begin
            op_coord_in[k] = CW'(idx_wrapped[seag_pkg::DimRegW-1:0]);
         end else begin
            op_coord_in[k] = cur_coord[k];
         end
      end
   end

   // shared multiply-accumulate with a sticky overflow flag
   logic [ADDR_BITS-1:0]                 acc_ff, acc_in;
   logic                                 ovf_ff, ovf_in;
   logic                                 idx_ok_ff;
   logic [seag_pkg::ValueW-1:0]          value_ff;
   logic [AW-1:0]                        seed_wide, sum;
   logic [ADDR_BITS+seag_pkg::DimRegW-1:0] prod;
   logic [seag_pkg::DimRegW-1:0]         dim_sel;
   logic [CW-1:0]                        coord_sel;
   logic                                 sum_hi;

   assign seed_wide = AW'(op_coord_in[0]);
   assign dim_sel   = cfg.out_dim[cmd.sel];
   assign coord_sel = op_coord_ff[cmd.sel];
   assign prod      = acc_ff * dim_sel;
   assign sum       = AW'(prod) + AW'(coord_sel);
   assign sum_hi    = |sum[AW-1:ADDR_BITS];

   always_comb begin
      acc_in = acc_ff;
      ovf_in = ovf_ff;
      if (cmd.load) begin
         acc_in = seed_wide[ADDR_BITS-1:0];
         ovf_in = |seed_wide[AW-1:ADDR_BITS];
      end else if (cmd.step) begin
         acc_in = sum[ADDR_BITS-1:0];
         // a zero dimension discards everything accumulated so far
         ovf_in = (dim_sel == '0) ? sum_hi : (ovf_ff | sum_hi);
      end
   end

   always_ff @(posedge clock) begin
      acc_ff <= acc_in;
      ovf_ff <= ovf_in;
      if (cmd.load) begin
         op_coord_ff <= op_coord_in;
         idx_ok_ff   <= idx_ok;
         value_ff    <= update_value;
      end
   end

   // output register
   logic [ADDR_BITS-1:0]        rsp_addr_ff;
   logic [seag_pkg::ValueW-1:0] rsp_value_ff;
   logic                        rsp_flag_ff;
   logic                        ok;

   assign ok = idx_ok_ff && !ovf_ff;

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_addr_ff  <= ok ? acc_ff : '0;
         rsp_value_ff <= value_ff;
         rsp_flag_ff  <= ok;
      end
   end

   assign write_addr  = rsp_addr_ff;
   assign write_value = rsp_value_ff;
   assign addr_valid  = rsp_flag_ff;

endmodule

// ===== src/scatter_elements_address_gen.sv =====
// scatter_elements_address_gen: write-address generator for scatter-elements on
// tensors padded to four dimensions
// Channels: req_ carries one update element per transfer (scatter index and value),
// in row-major order of the update shape; rsp_ returns one write per update with
// the linear output address, the value and an address-valid flag in tuser.
// csr_ writes the output and update dimensions and the axis slot by index; write
// only while no update is in flight.
// Flow: an update is taken when the block is idle; the transfer cycle captures
// it and wraps the index, the calc state runs the shared multiply-accumulate over
// the c, h and w dimensions in turn, and the hold state loads the output register,
// which raises rsp_tvalid; the block takes no new update until it is back in idle,
// so each update is finished before the next one is accepted.
// A finished result waits in the output register while the next update is
// taken and computed; if the receiver stalls, the block holds the next result
// until the register drains and takes no further update meanwhile.
// Reset (synchronous) clears the coordinate counters, sets all dimensions to 1,
// the axis slot to 3 (innermost) and empties the output register.
// depends on seag_pkg, seag_csr, seag_ctrl and seag_dp
module scatter_elements_address_gen #(
   parameter int ADDR_BITS = 24,
   parameter int DIM_BITS  = 12
) (
   input  logic                                   clock,
   input  logic                                   reset,
   // fields from bit 0: scatter_index[12:0], update_value[44:13], zero pad
   input  logic [47:0]                            req_tdata,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // fields from bit 0: write_addr[ADDR_BITS-1:0], write_value, zero pad
   output logic [((ADDR_BITS+32+7)/8)*8-1:0]      rsp_tdata,
   // fields from bit 0: addr_valid
   output logic                                   rsp_tuser,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   input  logic                                   csr_we,
   input  logic [seag_pkg::CsrIdxW-1:0]           csr_index,
   input  logic [seag_pkg::DimRegW-1:0]           csr_wdata
);

   localparam int RspW = ((ADDR_BITS + 32 + 7) / 8) * 8;

   seag_pkg::cfg_type           cfg;
   seag_pkg::cmd_type           cmd;
   logic [ADDR_BITS-1:0]        write_addr;
   logic [seag_pkg::ValueW-1:0] write_value;
   logic                        addr_valid;

   seag_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   seag_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   seag_dp #(
      .ADDR_BITS (ADDR_BITS),
      .DIM_BITS  (DIM_BITS)
   ) u_dp (
      .clock         (clock),
      .reset         (reset),
      .cfg           (cfg),
      .cmd           (cmd),
      .scatter_index ($signed(req_tdata[12:0])),
      .update_value  (req_tdata[44:13]),
      .write_addr    (write_addr),
      .write_value   (write_value),
      .addr_valid    (addr_valid)
   );

   assign rsp_tdata = RspW'({write_value, write_addr});
   assign rsp_tuser = addr_valid;

endmodule

// ===== test/tb_top.sv =====
// tb_top: self-checking testbench for scatter_elements_address_gen
// keeps its own copy of the shape registers and coordinate counters and checks every write
// depends on seag_pkg and the block's RTL
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int AddrBits = 24;
   localparam int DimBits  = 12;
   localparam int RspW     = ((AddrBits + seag_pkg::ValueW + 7) / 8) * 8;

   typedef struct packed {
      logic [AddrBits-1:0]         addr;
      logic [seag_pkg::ValueW-1:0] value;
      logic                        valid;
   } write_type;

   logic                          clock      = 1'b0;
   logic                          reset      = 1'b1;
   logic [47:0]                   req_tdata  = '0;
   logic                          req_tvalid = 1'b0;
   logic                          req_tready;
   logic [RspW-1:0]               rsp_tdata;
   logic                          rsp_tuser;
   logic                          rsp_tvalid;
   logic                          rsp_tready = 1'b0;
   logic                          csr_we     = 1'b0;
   logic [seag_pkg::CsrIdxW-1:0]  csr_index  = '0;
   logic [seag_pkg::DimRegW-1:0]  csr_wdata  = '0;

   // shape registers and coordinate counters as the block should hold them
   logic [seag_pkg::DimRegW-1:0]  out_dim [seag_pkg::NumDims];
   logic [seag_pkg::DimRegW-1:0]  upd_dim [seag_pkg::NumDims];  // entry 0 (n) unused
   logic [seag_pkg::AxisW-1:0]    axis;
   logic [DimBits-1:0]            coord [seag_pkg::NumDims];

   write_type pending_writes [$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int stall_request = 0;
   int stall_left    = 0;
   int fail_count    = 0;
   int updates_sent  = 0;
   int writes_checked = 0;
   int invalid_seen  = 0;
   int csr_writes    = 0;

   scatter_elements_address_gen #(
      .ADDR_BITS(AddrBits),
      .DIM_BITS (DimBits)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #4 clock = ~clock;

   initial begin
      #5ms;
      $display("[FAIL] regression broken");
      $finish;
   end

   // one counter step; returns 1 on wrap so the next counter carries
   function automatic bit bump(inout logic [DimBits-1:0] ctr,
                               input logic [seag_pkg::DimRegW-1:0] limit);
      int nxt;
      nxt = int'(ctr) + 1;
      if (nxt >= int'(limit) || nxt > (1 << DimBits) - 1) begin
         ctr = '0;
         return 1'b1;
      end
      ctr = nxt[DimBits-1:0];
      return 1'b0;
   endfunction

   function automatic void predict_write(input logic [seag_pkg::IndexW-1:0] raw,
                                         input logic [seag_pkg::ValueW-1:0] val);
      longint          idx;
      longint unsigned c [seag_pkg::NumDims];
      longint unsigned d [seag_pkg::NumDims];
      longint unsigned lin;
      write_type       w;
      int              k;
      idx = longint'($signed(raw));
      for (k = 0; k < seag_pkg::NumDims; k++) begin
         c[k] = 64'(coord[k]);
         d[k] = 64'(out_dim[k]);
      end
      w.value = val;
      w.valid = 1'b1;
      w.addr  = '0;
      // negative index counts from the end of the scatter axis
      if (idx < 0) idx += longint'(d[axis]);
      if (idx < 0 || idx >= d[axis]) begin
         w.valid = 1'b0;
      end else begin
         c[axis] = idx;
         lin = ((c[0] * d[1] + c[1]) * d[2] + c[2]) * d[3] + c[3];
         if (lin >= (64'd1 << AddrBits)) w.valid = 1'b0;
         else w.addr = lin[AddrBits-1:0];
      end
      pending_writes.push_back(w);
      if (bump(coord[3], upd_dim[3]))
         if (bump(coord[2], upd_dim[2]))
            if (bump(coord[1], upd_dim[1]))
               coord[0] = coord[0] + 1'b1;
   endfunction

   // result checker
   always @(posedge clock) begin
      write_type exp_w;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_writes.size() == 0) begin
            $error("write with no update pending: write_addr %0h", rsp_tdata[AddrBits-1:0]);
            fail_count++;
         end else begin
            exp_w = pending_writes.pop_front();
            writes_checked++;
            if (!exp_w.valid) invalid_seen++;
            if (rsp_tdata[AddrBits-1:0] !== exp_w.addr) begin
               $error("write_addr: expected %0h, got %0h", exp_w.addr,
                      rsp_tdata[AddrBits-1:0]);
               fail_count++;
            end
            if (rsp_tdata[AddrBits +: seag_pkg::ValueW] !== exp_w.value) begin
               $error("write_value: expected %0h, got %0h", exp_w.value,
                      rsp_tdata[AddrBits +: seag_pkg::ValueW]);
               fail_count++;
            end
            if (rsp_tuser !== exp_w.valid) begin
               $error("addr_valid: expected %0b, got %0b", exp_w.valid, rsp_tuser);
               fail_count++;
            end
         end
      end
   end

   // receiver: random stalls plus an occasional long hold-off
   always @(negedge clock) begin
      if (stall_request > 0) begin
         stall_left = stall_request;
         stall_request = 0;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   task automatic apply_reset();
      int k;
      for (k = 0; k < seag_pkg::NumDims; k++) begin
         out_dim[k] = seag_pkg::DimRegW'(1);
         upd_dim[k] = seag_pkg::DimRegW'(1);
         coord[k]   = '0;
      end
      axis = 2'd3;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
   endtask

   task automatic write_csr(input seag_pkg::csr_idx_type idx,
                            input logic [seag_pkg::DimRegW-1:0] data);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      if (idx == seag_pkg::CSR_AXIS_SLOT) axis = data[seag_pkg::AxisW-1:0];
      else if (idx <= seag_pkg::CSR_OUT_DIM_W) out_dim[int'(idx)] = data;
      else upd_dim[int'(idx) - int'(seag_pkg::CSR_OUT_DIM_W)] = data;
      csr_writes++;
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic write_shape(input logic [seag_pkg::DimRegW-1:0] on, oc, oh, ow,
                              uc, uh, uw, ax);
      write_csr(seag_pkg::CSR_OUT_DIM_N, on);
      write_csr(seag_pkg::CSR_OUT_DIM_C, oc);
      write_csr(seag_pkg::CSR_OUT_DIM_H, oh);
      write_csr(seag_pkg::CSR_OUT_DIM_W, ow);
      write_csr(seag_pkg::CSR_UPD_DIM_C, uc);
      write_csr(seag_pkg::CSR_UPD_DIM_H, uh);
      write_csr(seag_pkg::CSR_UPD_DIM_W, uw);
      write_csr(seag_pkg::CSR_AXIS_SLOT, ax);
   endtask

   task automatic send_update(input logic [seag_pkg::IndexW-1:0] idx,
                              input logic [seag_pkg::ValueW-1:0] val);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= {3'b000, val, idx};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_write(idx, val);
      updates_sent++;
   endtask

   // stop offering, wait for every write, then let the pipeline settle
   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   // mostly in range for the scatter axis, the rest anywhere in 13 bits
   function automatic logic [seag_pkg::IndexW-1:0] pick_index();
      int d;
      int v;
      d = int'(out_dim[axis]);
      if (d > 0 && d <= 4096 && $urandom_range(9) < 8) begin
         v = int'($urandom_range(2 * d - 1)) - d;
         return v[seag_pkg::IndexW-1:0];
      end
      return seag_pkg::IndexW'($urandom_range(8191));
   endfunction

   task automatic random_shape();
      logic [seag_pkg::DimRegW-1:0] od [seag_pkg::NumDims];
      logic [seag_pkg::DimRegW-1:0] ud [seag_pkg::NumDims];
      int k;
      for (k = 0; k < seag_pkg::NumDims; k++) begin
         case ($urandom_range(9))
            0: od[k] = 13'd4096;
            1: od[k] = 13'($urandom_range(1, 4096));
            default: od[k] = 13'($urandom_range(1, 6));
         endcase
         ud[k] = ($urandom_range(9) == 0) ? 13'd0 : 13'($urandom_range(1, 5));
      end
      write_shape(od[0], od[1], od[2], od[3], ud[1], ud[2], ud[3],
                  13'($urandom_range(8191)));
   endtask

   task automatic run_random(input int count);
      int i;
      for (i = 0; i < count; i++) begin
         if (i % 45 == 0) begin
            drain();
            random_shape();
         end
         send_update(pick_index(), $urandom);
      end
   endtask

   task automatic test_reset_defaults();
      send_update(13'h0000, 32'h0000_0000);
      send_update(13'h1fff, 32'hffff_ffff);  // -1 wraps to 0
      send_update(13'h0001, 32'h5a5a_5a5a);  // past the end
      send_update(13'h1ffe, 32'ha5a5_a5a5);  // still negative after wrap
      send_update(13'h0fff, 32'h8000_0001);
      send_update(13'h1000, 32'h7fff_fffe);
      drain();
   endtask

   task automatic test_axis_extremes();
      write_shape(13'd4096, 13'd4096, 13'd4096, 13'd4096, 13'd2, 13'd2, 13'd2, 13'd0);
      send_update(13'h0001, $urandom);  // far past capacity
      send_update(13'h1000, $urandom);  // -4096 wraps to 0
      drain();
      write_csr(seag_pkg::CSR_AXIS_SLOT, 13'd1);
      send_update(13'h0fff, $urandom);
      send_update(13'h0000, $urandom);
      drain();
      write_csr(seag_pkg::CSR_AXIS_SLOT, 13'd2);
      send_update(13'h1fff, $urandom);  // -1 wraps to 4095, yet the outer coordinates carry it past capacity
      send_update(13'h0fff, $urandom);
      drain();
      write_csr(seag_pkg::CSR_AXIS_SLOT, 13'd3);
      send_update(13'h0fff, $urandom);
      send_update(13'h0000, $urandom);
      drain();
   endtask

   task automatic test_odd_dims();
      // zero output dimension on the axis and zero update dimensions
      write_shape(13'h1fff, 13'h1fff, 13'h1fff, 13'd0, 13'd0, 13'd0, 13'd0, 13'd3);
      send_update(13'h0000, $urandom);
      send_update(13'h0064, $urandom);
      drain();
      write_csr(seag_pkg::CSR_OUT_DIM_W, 13'h1fff);
      write_csr(seag_pkg::CSR_AXIS_SLOT, 13'h1ffe);
      send_update(13'h0fff, $urandom);
      send_update(13'h1000, $urandom);
      drain();
   endtask

   task automatic test_random_traffic();
      send_idle_pct = 25;
      recv_idle_pct = 79;
      run_random(145);
      send_idle_pct = 79;
      recv_idle_pct = 25;
      run_random(145);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      run_random(145);
      drain();
   endtask

   task automatic test_backpressure();
      int i;
      write_shape(13'd3, 13'd4, 13'd5, 13'd6, 13'd2, 13'd3, 13'd4, 13'd2);
      send_idle_pct = 0;
      recv_idle_pct = 0;
      stall_request = 300;
      for (i = 0; i < 40; i++) send_update(pick_index(), $urandom);
      // sender holds back until every write is out
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending_writes.size() != 0) @(posedge clock);
      for (i = 0; i < 20; i++) send_update(pick_index(), $urandom);
      drain();
   endtask

   task automatic test_counter_wrap();
      int i;
      // w wraps every 2, h every 3 and c every 2, so carries reach the outermost counter
      write_shape(13'd8, 13'd2, 13'd3, 13'd2, 13'd2, 13'd3, 13'd2, 13'd1);
      for (i = 0; i < 40; i++) send_update(pick_index(), $urandom);
      drain();
   endtask

   initial begin
      apply_reset();
      test_reset_defaults();
      test_axis_extremes();
      test_odd_dims();
      test_random_traffic();
      test_backpressure();
      test_counter_wrap();
      $display("run covered %0d updates and %0d checked writes, %0d of them flagged invalid",
               updates_sent, writes_checked, invalid_seen);
      $display("%0d register writes across default, extreme, random and carry shapes",
               csr_writes);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
